// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and disabled
// while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

// ----- rtl/core/tlge_pkg.sv -----
// ----------------------------------------------------------------------------
// Life engine package
// Request/response types, function and register codes, sequencer states and
// the per-cell rule.
// ----------------------------------------------------------------------------
package tlge_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int MIN_DIM    = 3;
	localparam int RST_DIM    = 200;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

	localparam logic [1:0] FUNC_WRITE   = 2'd0;
	localparam logic [1:0] FUNC_READ    = 2'd1;
	localparam logic [1:0] FUNC_ADVANCE = 2'd2;

	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  row;
		logic [7:0]  col;
		logic        cell_in;
		logic [15:0] step_count;
	} req_t;

	typedef struct packed {
		logic        cell_out;
		logic [15:0] generations_done;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_G_LAST,
		ST_G_FIRST,
		ST_G_SECOND,
		ST_G_ROW,
		ST_RD,
		ST_CELL
	} state_t;

	// Conway rule: birth on 3, survival on 2 or 3.
	function automatic logic life_next(input logic alive, input logic [7:0] nbr);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'b000, nbr[i]};
		end
		return (n == BIRTH_COUNT) || (alive && (n == SURVIVE_COUNT));
	endfunction

endpackage

// ----- rtl/core/tlge_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlge_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/tlge_row_unit.sv -----
// ----------------------------------------------------------------------------
// Life row unit
// Next generation of one row from the rows above, at and below it, with
// horizontal wrap at the configured width. Columns past the width keep their
// value and never count as changed.
// ----------------------------------------------------------------------------
module tlge_row_unit #(
	parameter int GRID_W = 256,
	localparam int WW = $clog2(GRID_W + 1)
) (
	input  logic [GRID_W-1:0] above,
	input  logic [GRID_W-1:0] cur,
	input  logic [GRID_W-1:0] below,
	input  logic [WW-1:0]     width,
	output logic [GRID_W-1:0] next_row,
	output logic              changed
);

	localparam int CAW = $clog2(GRID_W);

	logic [CAW-1:0]    wm1;
	logic              a_wrap, c_wrap, b_wrap;
	logic [GRID_W-1:0] diff;

	// left neighbor of column 0 is the last column in use
	assign wm1    = CAW'(width - WW'(1));
	assign a_wrap = above[wm1];
	assign c_wrap = cur[wm1];
	assign b_wrap = below[wm1];

	for (genvar c = 0; c < GRID_W; c++) begin : g_col
		logic       in_use;
		logic       al, cl, bl, ar, cr, br;
		logic [7:0] nb;
		logic       nv;

		assign in_use = WW'(c) < width;

		if (c == 0) begin : g_left_wrap
			assign al = a_wrap;
			assign cl = c_wrap;
			assign bl = b_wrap;
		end else begin : g_left
			assign al = above[c-1];
			assign cl = cur[c-1];
			assign bl = below[c-1];
		end

		if (c == GRID_W - 1) begin : g_right_wrap
			assign ar = above[0];
			assign cr = cur[0];
			assign br = below[0];
		end else begin : g_right
			logic at_right;
			assign at_right = WW'(c + 1) == width;
			assign ar = at_right ? above[0] : above[c+1];
			assign cr = at_right ? cur[0]   : cur[c+1];
			assign br = at_right ? below[0] : below[c+1];
		end

		assign nb          = {al, above[c], ar, cl, cr, bl, below[c], br};
		assign nv          = tlge_pkg::life_next(cur[c], nb);
		assign next_row[c] = in_use ? nv : cur[c];
		assign diff[c]     = in_use && (nv != cur[c]);
	end

	assign changed = |diff;

endmodule

// ----- rtl/core/toroidal_life_generation_engine.sv -----
// ----------------------------------------------------------------------------
// Toroidal life generation engine: a cell request goes from IDLE to CELL and takes no new request until done.
// Advance: each generation runs G_LAST, G_FIRST, G_SECOND, then one grid row per cycle through the row RAM.
// Reset clears GRID_H rows; requests wait, config writes are taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

// The grid lives in one RAM of GRID_H rows, each GRID_W bits wide. A
// generation streams the rows through three row registers (above, current,
// below) and writes each new row back behind the read pointer:
//   G_LAST   read row h-1 (above neighbor of row 0)
//   G_FIRST  capture row h-1, read row 0
//   G_SECOND capture row 0 as current and as saved first row, read row 1
//   G_ROW    one row per cycle; the read runs two rows ahead of the write, so
//            no row is read after it was rewritten. The last row takes the
//            saved first row as its lower neighbor.
// A generation that changes no cell ends the request early; the generation
// count still advances by the full step count, added when the request is taken.
// Cell requests read the addressed row, then in CELL return the bit and, for
// a write inside the grid, write the row back with the bit replaced.
module toroidal_life_generation_engine #(
	parameter int GRID_W = 256,
	parameter int GRID_H = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  tlge_pkg::req_t                      in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output tlge_pkg::rsp_t                      out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tlge_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tlge_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CAW   = $clog2(GRID_W);
	localparam int WW    = $clog2(GRID_W + 1);
	localparam int RAW   = $clog2(GRID_H);
	localparam int HW    = $clog2(GRID_H + 1);
	localparam int CW    = HW + 1;
	localparam int RST_W = (tlge_pkg::RST_DIM > GRID_W) ? GRID_W : tlge_pkg::RST_DIM;
	localparam int RST_H = (tlge_pkg::RST_DIM > GRID_H) ? GRID_H : tlge_pkg::RST_DIM;

	tlge_pkg::state_t  state_q, state_d;
	logic [RAW-1:0]    scan_row_q;
	logic [15:0]       steps_q;
	logic              changed_q;
	logic [15:0]       gen_q;
	logic [WW-1:0]     eff_w_q;
	logic [HW-1:0]     eff_h_q;
	logic              out_valid_q;
	tlge_pkg::req_t    req_q;
	tlge_pkg::rsp_t    out_q;
	logic [GRID_W-1:0] above_q, cur_q, first_q;

	logic              ram_we;
	logic [RAW-1:0]    ram_waddr, ram_raddr;
	logic [GRID_W-1:0] ram_wdata, rdata;
	logic [GRID_W-1:0] below, next_row, cell_wdata;
	logic              row_changed;
	logic              in_accept, in_inside, req_inside, fire;
	logic              last_row, clear_done, is_write, cell_value;
	logic [RAW-1:0]    in_row_addr, req_row_addr;
	logic [CAW-1:0]    req_col_idx;
	logic [CW-1:0]     row_plus2;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == tlge_pkg::ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// addresses outside the grid never write the RAM; they read row 0
	assign in_inside    = (in_data.row < eff_h_q) && (in_data.col < eff_w_q);
	assign req_inside   = (req_q.row < eff_h_q) && (req_q.col < eff_w_q);
	assign in_row_addr  = in_inside ? RAW'(in_data.row) : '0;
	assign req_row_addr = req_inside ? RAW'(req_q.row) : '0;
	assign req_col_idx  = CAW'(req_q.col);
	assign is_write     = (req_q.func == tlge_pkg::FUNC_WRITE);

	assign last_row   = (CW'(scan_row_q) + CW'(1)) == CW'(eff_h_q);
	assign row_plus2  = CW'(scan_row_q) + CW'(2);
	assign clear_done = scan_row_q == RAW'(GRID_H - 1);
	assign below      = last_row ? first_q : rdata;

	// result register is free or being emptied this cycle
	assign fire = (state_q == tlge_pkg::ST_CELL) && (!out_valid_q || out_ready);

	assign cell_value = req_inside && (is_write ? req_q.cell_in : rdata[req_col_idx]);

	always_comb begin
		cell_wdata              = rdata;
		cell_wdata[req_col_idx] = req_q.cell_in;
	end

	tlge_ram #(
		.WIDTH (GRID_W),
		.DEPTH (GRID_H)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	tlge_row_unit #(
		.GRID_W (GRID_W)
	) u_row (
		.above    (above_q),
		.cur      (cur_q),
		.below    (below),
		.width    (eff_w_q),
		.next_row (next_row),
		.changed  (row_changed)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlge_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM port control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = scan_row_q;
		ram_wdata = next_row;
		ram_raddr = req_row_addr;
		unique case (state_q)
			tlge_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
				if (clear_done) begin
					state_d = tlge_pkg::ST_IDLE;
				end
			end
			tlge_pkg::ST_IDLE: begin
				ram_raddr = in_row_addr;
				if (in_valid) begin
					if (in_data.func == tlge_pkg::FUNC_ADVANCE && in_data.step_count != '0) begin
						state_d = tlge_pkg::ST_G_LAST;
					end else begin
						state_d = tlge_pkg::ST_CELL;
					end
				end
			end
			tlge_pkg::ST_G_LAST: begin
				ram_raddr = RAW'(eff_h_q - HW'(1));
				state_d   = tlge_pkg::ST_G_FIRST;
			end
			tlge_pkg::ST_G_FIRST: begin
				ram_raddr = '0;
				state_d   = tlge_pkg::ST_G_SECOND;
			end
			tlge_pkg::ST_G_SECOND: begin
				ram_raddr = RAW'(1);
				state_d   = tlge_pkg::ST_G_ROW;
			end
			tlge_pkg::ST_G_ROW: begin
				ram_raddr = (row_plus2 < CW'(eff_h_q)) ? RAW'(row_plus2) : '0;
				ram_we    = 1'b1;
				if (last_row) begin
					if ((changed_q || row_changed) && steps_q != 16'd1) begin
						state_d = tlge_pkg::ST_G_LAST;
					end else begin
						state_d = tlge_pkg::ST_RD;
					end
				end
			end
			tlge_pkg::ST_RD: begin
				state_d = tlge_pkg::ST_CELL;
			end
			tlge_pkg::ST_CELL: begin
				if (fire) begin
					ram_we    = is_write && req_inside;
					ram_waddr = req_row_addr;
					ram_wdata = cell_wdata;
					state_d   = tlge_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tlge_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q  <= '0;
			steps_q     <= '0;
			changed_q   <= 1'b0;
			gen_q       <= '0;
			eff_w_q     <= WW'(RST_W);
			eff_h_q     <= HW'(RST_H);
			out_valid_q <= 1'b0;
		end else begin
			// sizes are stored already clamped to the usable range
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					tlge_pkg::REG_GRID_WIDTH: begin
						if (int'(cfg_data) < tlge_pkg::MIN_DIM) begin
							eff_w_q <= WW'(tlge_pkg::MIN_DIM);
						end else if (int'(cfg_data) > GRID_W) begin
							eff_w_q <= WW'(GRID_W);
						end else begin
							eff_w_q <= WW'(cfg_data);
						end
					end
					tlge_pkg::REG_GRID_HEIGHT: begin
						if (int'(cfg_data) < tlge_pkg::MIN_DIM) begin
							eff_h_q <= HW'(tlge_pkg::MIN_DIM);
						end else if (int'(cfg_data) > GRID_H) begin
							eff_h_q <= HW'(GRID_H);
						end else begin
							eff_h_q <= HW'(cfg_data);
						end
					end
					default: begin
					end
				endcase
			end

			case (state_q)
				tlge_pkg::ST_CLEAR: begin
					scan_row_q <= clear_done ? '0 : scan_row_q + RAW'(1);
				end
				tlge_pkg::ST_IDLE: begin
					if (in_accept) begin
						steps_q    <= in_data.step_count;
						changed_q  <= 1'b0;
						scan_row_q <= '0;
						if (in_data.func == tlge_pkg::FUNC_ADVANCE) begin
							gen_q <= gen_q + in_data.step_count;
						end
					end
				end
				tlge_pkg::ST_G_ROW: begin
					if (last_row) begin
						scan_row_q <= '0;
						steps_q    <= steps_q - 16'd1;
						changed_q  <= 1'b0;
					end else begin
						scan_row_q <= scan_row_q + RAW'(1);
						changed_q  <= changed_q || row_changed;
					end
				end
				default: begin
				end
			endcase

			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q <= in_data;
		end
		if (state_q == tlge_pkg::ST_G_FIRST) begin
			above_q <= rdata;
		end
		if (state_q == tlge_pkg::ST_G_SECOND) begin
			cur_q   <= rdata;
			first_q <= rdata;
		end
		if (state_q == tlge_pkg::ST_G_ROW) begin
			above_q <= cur_q;
			cur_q   <= below;
		end
		if (fire) begin
			out_q.cell_out         <= cell_value;
			out_q.generations_done <= gen_q;
		end
	end

	// Row sweep never runs past the configured height.
	`ASSERT_IMPLY(a_row_in_grid, clk, arst_n, state_q == tlge_pkg::ST_G_ROW, CW'(scan_row_q) < CW'(eff_h_q))
	// A cell request goes straight to the response state.
	`ASSERT_NEXT(a_cell_direct, clk, arst_n, in_accept && in_data.func != tlge_pkg::FUNC_ADVANCE, state_q == tlge_pkg::ST_CELL)
	// A response is only ever loaded from the response state.
	`ASSERT_IMPLY(a_rsp_from_cell, clk, arst_n, $rose(out_valid_q), $past(state_q) == tlge_pkg::ST_CELL)
	// The generation count moves only when a request is taken.
	`ASSERT_NEXT(a_gen_hold, clk, arst_n, !in_accept, $stable(gen_q))

endmodule

// ----- test/toroidal_life_generation_engine_tb.sv -----
// ----------------------------------------------------------------------------
// Toroidal life generation engine testbench
// Drives cell write, cell read and advance requests through the valid/ready
// request port while the grid size registers step through small, odd, clamped
// and full settings. Every response is checked field by field against a
// behavioral life grid kept inside the bench, or against a typed directed row.
// ----------------------------------------------------------------------------
module toroidal_life_generation_engine_tb;

	localparam int GRID_W      = 256;
	localparam int GRID_H      = 256;
	localparam int STALL_LIMIT = 40000;  // cycles with no handshake at all
	localparam int SETTLE_GENS = 24;     // big step counts only if the grid goes still by then
	localparam int HOLD_CYCLES = 400;    // long receiver hold-off
	localparam int DIR_ROWS    = 17;
	localparam int PHASES      = 11;

	// Function code the block does not name; it must behave as a read.
	localparam logic [1:0] FUNC_SPARE = 2'd3;
	// Register indexes with no register behind them.
	localparam logic [tlge_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [tlge_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct {
		tlge_pkg::req_t req;
		bit             typed;  // response written into the table by hand
		tlge_pkg::rsp_t want;
	} dir_row_t;

	typedef struct {
		int w_raw;
		int h_raw;
		int items;
		bit steady;   // no sender gaps in this phase
	} phase_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	tlge_pkg::req_t                  in_data;
	logic                            out_valid;
	logic                            out_ready;
	tlge_pkg::rsp_t                  out_data;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [tlge_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tlge_pkg::CFG_DATA_W-1:0] cfg_data;

	// Behavioral grid: row r lives in life_cells[r], column c is bit c.
	bit [GRID_W-1:0]                 life_cells [GRID_H];
	bit [GRID_W-1:0]                 life_next_cells [GRID_H];
	bit [GRID_W-1:0]                 life_saved_cells [GRID_H];
	logic [tlge_pkg::CFG_DATA_W-1:0] cols_setting = tlge_pkg::CFG_DATA_W'(tlge_pkg::RST_DIM);
	logic [tlge_pkg::CFG_DATA_W-1:0] rows_setting = tlge_pkg::CFG_DATA_W'(tlge_pkg::RST_DIM);
	logic [15:0]                     gen_total = '0;

	tlge_pkg::rsp_t awaited_reports [$];
	tlge_pkg::rsp_t report_want;
	int             mismatches = 0;
	int             stall_cycles = 0;
	int             hold_offs_asked = 0;
	dir_row_t       dir_table [DIR_ROWS];
	phase_t         phase_list [PHASES];

	toroidal_life_generation_engine #(
		.GRID_W(GRID_W),
		.GRID_H(GRID_H)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Grid model
	// ------------------------------------------------------------------

	// Size register to the span actually used: clamped to 3..grid limit.
	function automatic int span_of(logic [tlge_pkg::CFG_DATA_W-1:0] raw, int limit);
		if (raw < tlge_pkg::MIN_DIM)
			return tlge_pkg::MIN_DIM;
		if (raw > limit)
			return limit;
		return int'(raw);
	endfunction

	// One generation over the active window, all counts from the old grid.
	// Cells outside the window are left alone. Returns 1 if any cell changed.
	function automatic bit evolve_once();
		int w, h, r, c, up, dn, lt, rt, n;
		bit alive, nv, changed;
		w = span_of(cols_setting, GRID_W);
		h = span_of(rows_setting, GRID_H);
		changed = 1'b0;
		for (r = 0; r < h; r++) begin
			up = (r == 0) ? h - 1 : r - 1;
			dn = (r == h - 1) ? 0 : r + 1;
			life_next_cells[r] = life_cells[r];
			for (c = 0; c < w; c++) begin
				lt = (c == 0) ? w - 1 : c - 1;
				rt = (c == w - 1) ? 0 : c + 1;
				n = life_cells[up][lt] + life_cells[up][c] + life_cells[up][rt]
					+ life_cells[r][lt] + life_cells[r][rt]
					+ life_cells[dn][lt] + life_cells[dn][c] + life_cells[dn][rt];
				alive = life_cells[r][c];
				nv = (n == tlge_pkg::BIRTH_COUNT) || (alive && (n == tlge_pkg::SURVIVE_COUNT));
				if (nv != alive)
					changed = 1'b1;
				life_next_cells[r][c] = nv;
			end
		end
		for (r = 0; r < h; r++)
			life_cells[r] = life_next_cells[r];
		return changed;
	endfunction

	// Dry run: does the grid stop changing within the given generations?
	function automatic bit settles_early(int limit);
		int k;
		bit still;
		life_saved_cells = life_cells;
		still = 1'b0;
		for (k = 0; k < limit; k++) begin
			if (!evolve_once()) begin
				still = 1'b1;
				break;
			end
		end
		life_cells = life_saved_cells;
		return still;
	endfunction

	// Apply one request to the grid and return the response it must produce.
	function automatic tlge_pkg::rsp_t apply_request(tlge_pkg::req_t q);
		int w, h, k;
		bit in_grid;
		tlge_pkg::rsp_t res;
		w = span_of(cols_setting, GRID_W);
		h = span_of(rows_setting, GRID_H);
		in_grid = (q.row < h) && (q.col < w);
		case (q.func)
			tlge_pkg::FUNC_WRITE: begin
				if (in_grid)
					life_cells[q.row][q.col] = q.cell_in;
			end
			tlge_pkg::FUNC_ADVANCE: begin
				// A still generation ends the work; the count still moves on in full.
				for (k = 0; k < q.step_count; k++) begin
					if (!evolve_once())
						break;
				end
				gen_total = gen_total + q.step_count;
			end
			default: ;  // read, and the spare code acts as a read
		endcase
		res.cell_out = in_grid ? life_cells[q.row][q.col] : 1'b0;
		res.generations_done = gen_total;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic dir_row_t dir_row(logic [1:0] f, int r, int c, bit v, int s,
			bit typed, bit want_cell, int want_gen);
		dir_row_t d;
		d.req.func = f;
		d.req.row = 8'(r);
		d.req.col = 8'(c);
		d.req.cell_in = v;
		d.req.step_count = 16'(s);
		d.typed = typed;
		d.want.cell_out = want_cell;
		d.want.generations_done = 16'(want_gen);
		return d;
	endfunction

	// Large counts only where the grid goes still soon, so the block (and the
	// model) stop early; oscillating grids get a handful of generations.
	function automatic logic [15:0] choose_steps(bit big_grid);
		int pick;
		if (big_grid)
			return 16'($urandom_range(0, 1));
		pick = $urandom_range(0, 9);
		if (pick < 3 && settles_early(SETTLE_GENS))
			return (pick == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 4));
	endfunction

	// Mostly writes and reads inside the window with advances mixed in, plus
	// noise requests with any code and any address.
	function automatic tlge_pkg::req_t random_request(bit big_grid);
		int w, h, sel;
		tlge_pkg::req_t q;
		w = span_of(cols_setting, GRID_W);
		h = span_of(rows_setting, GRID_H);
		sel = $urandom_range(0, 99);
		q.row = 8'($urandom_range(0, h - 1));
		q.col = 8'($urandom_range(0, w - 1));
		q.cell_in = 1'($urandom_range(0, 1));
		q.step_count = 16'($urandom_range(0, 65535));
		if (sel < 45) begin
			q.func = tlge_pkg::FUNC_WRITE;
		end else if (sel < 70) begin
			q.func = tlge_pkg::FUNC_READ;
		end else if (sel < (big_grid ? 73 : 85)) begin
			q.func = tlge_pkg::FUNC_ADVANCE;
			q.step_count = choose_steps(big_grid);
		end else begin
			q.func = 2'($urandom_range(0, 3));
			q.row = 8'($urandom_range(0, 255));
			q.col = 8'($urandom_range(0, 255));
			if (q.func == tlge_pkg::FUNC_ADVANCE)
				q.step_count = choose_steps(big_grid);
		end
		return q;
	endfunction

	// Offer one request, hold it until taken, then log what it must return.
	task automatic send_request(tlge_pkg::req_t q, bit typed, tlge_pkg::rsp_t want);
		tlge_pkg::rsp_t pred;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= q;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = apply_request(q);
		awaited_reports.push_back(typed ? want : pred);
	endtask

	task automatic idle_gap(int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Stop offering and wait until every response is back, then let the
	// block settle.
	task automatic drain_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [tlge_pkg::CFG_IDX_W-1:0] idx,
			logic [tlge_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			tlge_pkg::REG_GRID_WIDTH:  cols_setting = val;
			tlge_pkg::REG_GRID_HEIGHT: rows_setting = val;
			default: ;  // unmapped index: nothing changes
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int p, i, burst_left;
		bit big_grid;
		tlge_pkg::rsp_t none;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		none = '0;
		burst_left = 0;

		// Directed rows run on the 200 x 200 reset size.
		dir_table = '{
			// empty grid after reset, inside and outside the window
			dir_row(tlge_pkg::FUNC_READ,      0,   0, 0,     0, 1, 0,     0),
			dir_row(tlge_pkg::FUNC_READ,    255, 255, 0,     0, 1, 0,     0),
			// write in the last cell, then writes just past the window
			dir_row(tlge_pkg::FUNC_WRITE,   199, 199, 1,     0, 1, 1,     0),
			dir_row(tlge_pkg::FUNC_WRITE,   200,   5, 1,     0, 1, 0,     0),
			dir_row(tlge_pkg::FUNC_WRITE,     5, 255, 1,     0, 1, 0,     0),
			// unused code reads back the cell
			dir_row(FUNC_SPARE,             199, 199, 0, 65535, 1, 1,     0),
			dir_row(tlge_pkg::FUNC_WRITE,   199, 199, 0,     0, 1, 0,     0),
			// zero steps changes nothing
			dir_row(tlge_pkg::FUNC_ADVANCE,   0,   0, 1,     0, 1, 0,     0),
			// still grid: the full count is taken, then the counter wraps
			dir_row(tlge_pkg::FUNC_ADVANCE,   0,   0, 0, 65535, 1, 0, 65535),
			dir_row(tlge_pkg::FUNC_ADVANCE,   0,   0, 0,     1, 1, 0,     0),
			// blinker across the left/right seam, flipping over the top/bottom seam
			dir_row(tlge_pkg::FUNC_WRITE,     0, 199, 1,     0, 0, 0,     0),
			dir_row(tlge_pkg::FUNC_WRITE,     0,   0, 1,     0, 0, 0,     0),
			dir_row(tlge_pkg::FUNC_WRITE,     0,   1, 1,     0, 0, 0,     0),
			dir_row(tlge_pkg::FUNC_ADVANCE, 199,   0, 0,     1, 0, 0,     0),
			dir_row(tlge_pkg::FUNC_READ,      1,   0, 0,     0, 0, 0,     0),
			dir_row(tlge_pkg::FUNC_ADVANCE,   0, 199, 0,     2, 0, 0,     0),
			dir_row(tlge_pkg::FUNC_READ,      0,   1, 0,     0, 0, 0,     0)
		};

		// Raw register values include below-minimum and above-maximum settings.
		phase_list = '{
			'{3,   3,   180, 0},
			'{1,   5,   150, 1},
			'{4,   4,   200, 0},
			'{8,   6,   200, 0},
			'{256, 3,   150, 0},
			'{3,   256, 150, 0},
			'{511, 511, 120, 0},
			'{12,  10,  200, 1},
			'{257, 2,   100, 0},
			'{5,   7,   200, 0},
			'{16,  16,  200, 0}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIR_ROWS; i++)
			send_request(dir_table[i].req, dir_table[i].typed, dir_table[i].want);

		for (p = 0; p < PHASES; p++) begin
			drain_idle();
			if (p == 2) begin
				write_reg(REG_SPARE_A, 9'h155);
				write_reg(REG_SPARE_B, 9'h0AA);
			end
			write_reg(tlge_pkg::REG_GRID_WIDTH,
				tlge_pkg::CFG_DATA_W'(phase_list[p].w_raw));
			write_reg(tlge_pkg::REG_GRID_HEIGHT,
				tlge_pkg::CFG_DATA_W'(phase_list[p].h_raw));
			big_grid = span_of(cols_setting, GRID_W) * span_of(rows_setting, GRID_H) > 2048;
			for (i = 0; i < phase_list[p].items; i++) begin
				// receiver holds off while requests keep coming
				if ((p == 2 || p == 9) && i == 40)
					hold_offs_asked++;
				// full stop mid-phase until everything is back
				if (p == 3 && i == 100)
					drain_idle();
				if (!phase_list[p].steady) begin
					if (burst_left == 0) begin
						idle_gap($urandom_range(1, 8));
						burst_left = $urandom_range(1, 24);
					end
					burst_left--;
				end
				send_request(random_request(big_grid), 1'b0, none);
			end
		end

		drain_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Response side: stall pattern changes every so often; on request it
	// holds off for a long stretch so the block backs up into its input.
	// ------------------------------------------------------------------
	initial begin
		int mode, mode_left, holds_done;
		out_ready = 1'b0;
		mode = 0;
		mode_left = 0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (holds_done < hold_offs_asked) begin
				holds_done++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Response check: oldest expectation first, field by field.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_reports.size() == 0) begin
				$error("response with no request outstanding: cell_out %0d gens %0d",
					out_data.cell_out, out_data.generations_done);
				mismatches++;
			end else begin
				report_want = awaited_reports.pop_front();
				if (out_data.cell_out !== report_want.cell_out) begin
					$error("cell_out: expected %0d, got %0d",
						report_want.cell_out, out_data.cell_out);
					mismatches++;
				end
				if (out_data.generations_done !== report_want.generations_done) begin
					$error("generations_done: expected %0d, got %0d",
						report_want.generations_done, out_data.generations_done);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any handshake on any channel restarts the count.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n)
			stall_cycles <= 0;
		else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/tlge_pkg.sv
rtl/core/tlge_ram.sv
rtl/core/tlge_row_unit.sv
rtl/core/toroidal_life_generation_engine.sv
test/toroidal_life_generation_engine_tb.sv
